>>> rtl/vn_pkg.sv
// vector normalizer package: shared constants for the normalizer pipeline
// no dependencies; used by vn_div_stage, vector_normalizer_top, the checker and the testbench
`default_nettype none

package vn_pkg;

  localparam int FRAC_BITS = 16;   // fraction bits of q16.16
  localparam int Q_BITS    = 17;   // quotient bits, result magnitude never exceeds 1.0
  localparam int OUT_W     = 32;   // width of one output component
  localparam int LEN_W     = 33;   // width of the length field

  localparam logic [OUT_W-1:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] MIN_LEN_SQ_RST = 32'd4295;

  localparam logic OP_XYZ  = 1'b0;  // normalize xyz, keep w
  localparam logic OP_XYZW = 1'b1;  // normalize all four

endpackage

`default_nettype wire

>>> rtl/vn_sqrt_stage.sv
// vector normalizer: one bit of the pipelined integer square root
// no package dependency; instantiated by vector_normalizer_top
`default_nettype none

module vn_sqrt_stage #(
  parameter int SW    = 66,
  parameter int SHIFT = 64
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [SW-1:0] rem_i,
  input  wire logic [SW-1:0] root_i,
  output logic      [SW-1:0] rem_o,
  output logic      [SW-1:0] root_o
);

  logic [SW-1:0] bit_w;
  logic [SW-1:0] trial;
  logic [SW-1:0] rem_nxt;
  logic [SW-1:0] root_nxt;

  assign bit_w = {{(SW-1){1'b0}}, 1'b1} << SHIFT;
  assign trial = root_i + bit_w;

  always_comb begin
    if (rem_i >= trial) begin
      rem_nxt  = rem_i - trial;
      root_nxt = (root_i >> 1) + bit_w;
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vn_div_stage.sv
// vector normalizer: one quotient bit of the pipelined restoring divider
// depends on vn_pkg; instantiated by vector_normalizer_top
`default_nettype none

module vn_div_stage #(
  parameter int DW = 49,
  parameter int LW = 33,
  parameter int K  = 16
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [DW-1:0]             rem_i,
  input  wire logic [LW-1:0]             den_i,
  input  wire logic [vn_pkg::Q_BITS-1:0] q_i,
  output logic      [DW-1:0]             rem_o,
  output logic      [LW-1:0]             den_o,
  output logic      [vn_pkg::Q_BITS-1:0] q_o
);

  logic [DW-1:0]             den_sh;
  logic [DW-1:0]             rem_nxt;
  logic [vn_pkg::Q_BITS-1:0] q_nxt;

  assign den_sh = {{(DW-LW){1'b0}}, den_i} << K;

  always_comb begin
    rem_nxt = rem_i;
    q_nxt   = q_i;
    if (rem_i >= den_sh) begin
      rem_nxt  = rem_i - den_sh;
      q_nxt[K] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= rem_nxt;
      den_o <= den_i;
      q_o   <= q_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vector_normalizer_top.sv
// vector normalizer top level: input decode, squares, sum, sqrt and divider pipelines
// depends on vn_pkg, vn_sqrt_stage and vn_div_stage
`default_nettype none

// Normalizes a four-component signed q16.16 vector, one beat per cycle. Each beat runs
// through a fixed pipeline of 3 + (COMPONENT_BITS+1) + 17 register stages (53 at the
// default width): input decode, per-component squares, the squared-length sum with the
// threshold compare, one stage per root bit of the square root, and one stage per
// quotient bit of four parallel restoring dividers. Latency is set by those bit-serial
// chains; throughput is one beat per clock. The whole pipeline advances together and
// freezes while a result waits on out_tready, so nothing is dropped or repeated.
// A vector whose squared length is not above min_length_sq comes out as (1,0,0,w) or
// (1,0,0,0) with length 0 and the degenerate flag set.
module vector_normalizer_top #(
  parameter int COMPONENT_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // in_x, in_y, in_z, in_w (32 bits each, lowest first)
  input  wire logic [0:0]   in_tuser,   // operation
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [167:0] out_tdata,  // out_x, out_y, out_z, out_w, orig_length(33), pad
  output logic      [0:0]   out_tuser,  // degenerate
  // configuration
  input  wire logic         cfg_wr_en,
  input  wire logic [31:0]  cfg_wr_data
);

  localparam int CB  = COMPONENT_BITS;
  localparam int SW  = 2 * CB + 2;              // squared length, padded to even width
  localparam int LW  = CB + 1;                  // length width
  localparam int NSQ = LW;                      // root bits
  localparam int QW  = vn_pkg::Q_BITS;
  localparam int DW  = CB + vn_pkg::FRAC_BITS + 1;
  localparam int NST = 3 + NSQ + QW;            // total pipeline stages
  localparam int OW  = vn_pkg::OUT_W;

  typedef struct packed {
    logic                 op;
    logic                 degen;
    logic [3:0]           neg;
    logic [3:0][CB-1:0]   mag;
  } side_t;

  logic [31:0]   min_len_sq_r;
  logic          en;
  logic [NST-1:0] valid_r;
  side_t         side_r [NST];
  side_t         side_nxt;
  side_t         side2_nxt;
  logic [2*CB-1:0] sq_r [4];
  logic [SW-1:0] sum_r;
  logic [SW-1:0] sum_nxt;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_sq_r <= vn_pkg::MIN_LEN_SQ_RST;
    end else if (cfg_wr_en) begin
      min_len_sq_r <= cfg_wr_data;
    end
  end

  // pipeline advances when the output slot is free or being drained
  assign en        = out_tready || !valid_r[NST-1];
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NST-2:0], in_tvalid};
    end
  end

  // stage 0: sign extend from the component width and split into sign and magnitude
  always_comb begin
    logic [CB-1:0] raw;
    side_nxt       = '0;
    side_nxt.op    = in_tuser[0];
    for (int i = 0; i < 4; i++) begin
      raw              = in_tdata[32*i +: CB];
      side_nxt.neg[i]  = raw[CB-1];
      side_nxt.mag[i]  = raw[CB-1] ? (~raw + 1'b1) : raw;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
    end
  end

  // stage 1: squares, w only counts for the four-component operation
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        if (i == 3 && side_r[0].op == vn_pkg::OP_XYZ) begin
          sq_r[i] <= '0;
        end else begin
          sq_r[i] <= side_r[0].mag[i] * side_r[0].mag[i];
        end
      end
      side_r[1] <= side_r[0];
    end
  end

  // stage 2: exact squared length and threshold compare
  assign sum_nxt = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]} + {2'b00, sq_r[3]};

  always_comb begin
    side2_nxt       = side_r[1];
    side2_nxt.degen = !(sum_nxt > {{(SW-32){1'b0}}, min_len_sq_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r     <= sum_nxt;
      side_r[2] <= side2_nxt;
    end
  end

  // sideband follows the sqrt and divider stages
  genvar gs;
  generate
    for (gs = 3; gs < NST; gs++) begin : g_side
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[gs] <= side_r[gs-1];
        end
      end
    end
  endgenerate

  // square root, one root bit per stage
  logic [SW-1:0] srem  [NSQ+1];
  logic [SW-1:0] sroot [NSQ+1];

  assign srem[0]  = sum_r;
  assign sroot[0] = '0;

  genvar gq;
  generate
    for (gq = 0; gq < NSQ; gq++) begin : g_sqrt
      vn_sqrt_stage #(
        .SW    (SW),
        .SHIFT (2 * (NSQ - 1 - gq))
      ) u_sqrt (
        .clk    (clk),
        .en     (en),
        .rem_i  (srem[gq]),
        .root_i (sroot[gq]),
        .rem_o  (srem[gq+1]),
        .root_o (sroot[gq+1])
      );
    end
  endgenerate

  // four dividers, one quotient bit per stage, msb first
  logic [DW-1:0] drem [4][QW+1];
  logic [LW-1:0] dden [4][QW+1];
  logic [QW-1:0] dq   [4][QW+1];

  genvar gl, gd;
  generate
    for (gl = 0; gl < 4; gl++) begin : g_lane
      assign drem[gl][0] = {1'b0, side_r[2+NSQ].mag[gl], {vn_pkg::FRAC_BITS{1'b0}}};
      assign dden[gl][0] = sroot[NSQ][LW-1:0];
      assign dq[gl][0]   = '0;
      for (gd = 0; gd < QW; gd++) begin : g_div
        vn_div_stage #(
          .DW (DW),
          .LW (LW),
          .K  (QW - 1 - gd)
        ) u_div (
          .clk   (clk),
          .en    (en),
          .rem_i (drem[gl][gd]),
          .den_i (dden[gl][gd]),
          .q_i   (dq[gl][gd]),
          .rem_o (drem[gl][gd+1]),
          .den_o (dden[gl][gd+1]),
          .q_o   (dq[gl][gd+1])
        );
      end
    end
  endgenerate

  // result formatting from the last stage
  side_t         fin;
  logic [OW-1:0] qs [4];
  logic [OW-1:0] w_pass;
  logic [OW-1:0] ox, oy, oz, ow;
  logic [vn_pkg::LEN_W-1:0] olen;

  assign fin = side_r[NST-1];

  always_comb begin
    logic [OW-1:0] qe;
    logic [OW-1:0] me;
    for (int i = 0; i < 4; i++) begin
      qe    = {{(OW-QW){1'b0}}, dq[i][QW]};
      qs[i] = fin.neg[i] ? (~qe + 1'b1) : qe;
    end
    me     = {{(OW-CB){1'b0}}, fin.mag[3]};
    w_pass = fin.neg[3] ? (~me + 1'b1) : me;
  end

  always_comb begin
    if (fin.degen) begin
      ox   = vn_pkg::ONE_Q16;
      oy   = '0;
      oz   = '0;
      ow   = (fin.op == vn_pkg::OP_XYZW) ? '0 : w_pass;
      olen = '0;
    end else begin
      ox   = qs[0];
      oy   = qs[1];
      oz   = qs[2];
      ow   = (fin.op == vn_pkg::OP_XYZW) ? qs[3] : w_pass;
      olen = {{(vn_pkg::LEN_W-LW){1'b0}}, dden[0][QW]};
    end
  end

  assign out_tvalid = valid_r[NST-1];
  assign out_tdata  = {7'b0, olen, ow, oz, oy, ox};
  assign out_tuser  = fin.degen;

  // a degenerate result carries the unit x and a zero length
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[31:0] == vn_pkg::ONE_Q16
                                   && out_tdata[160:128] == '0)
    else $error("degenerate result not formatted");

  // the normalized x and y quotients never exceed 1.0 in magnitude
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> dq[0][QW] <= 17'h10000 && dq[1][QW] <= 17'h10000)
    else $error("quotient out of range");

  // the pipeline only stalls while a result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("pipeline stalled without back-pressure");

endmodule

`default_nettype wire

>>> dv/vector_normalizer_checker.sv
// result checker for vector_normalizer_top: watches both streams, predicts, compares
// depends on vn_pkg for the operation codes, the unit value and the register reset value
`default_nettype none

module vector_normalizer_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [127:0] in_tdata,
  input  wire logic [0:0]   in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [167:0] out_tdata,
  input  wire logic [0:0]   out_tuser,
  input  wire logic         cfg_wr_en,
  input  wire logic [31:0]  cfg_wr_data,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic        degen;
    logic [32:0] len;
    logic [31:0] w, z, y, x;
  } norm_vec_t;

  logic [31:0] thresh_sq;
  norm_vec_t   norm_q[$];

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic norm_vec_t normalize(logic op, logic [127:0] d, logic [31:0] th);
    norm_vec_t   e;
    logic [31:0] comp [4];
    logic [32:0] mag [4];
    logic        neg [4];
    logic [64:0] sum;
    logic [32:0] len;
    logic [63:0] q;
    int          n;
    n = (op == vn_pkg::OP_XYZW) ? 4 : 3;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      comp[i] = d[32*i +: 32];
      neg[i] = comp[i][31];
      mag[i] = neg[i] ? 33'(-{1'b1, comp[i]}) : {1'b0, comp[i]};
    end
    for (int i = 0; i < n; i++) sum = sum + 65'(64'(mag[i]) * 64'(mag[i]));
    e.w = comp[3];
    if (sum > 65'(th)) begin
      len = sum[64] ? 33'h1_0000_0000 : 33'(root_floor(sum[63:0]));
      for (int i = 0; i < n; i++) begin
        q = (64'(mag[i]) << 16) / 64'(len);
        comp[i] = neg[i] ? -q[31:0] : q[31:0];
      end
      e.x = comp[0];
      e.y = comp[1];
      e.z = comp[2];
      if (n == 4) e.w = comp[3];
      e.len = len;
      e.degen = 1'b0;
    end else begin
      e.x = vn_pkg::ONE_Q16;
      e.y = 0;
      e.z = 0;
      if (op == vn_pkg::OP_XYZW) e.w = 0;
      e.len = 0;
      e.degen = 1'b1;
    end
    return e;
  endfunction

  always @(posedge clk) begin
    norm_vec_t e;
    norm_vec_t got;
    if (!rst_n) begin
      thresh_sq <= vn_pkg::MIN_LEN_SQ_RST;
    end else begin
      if (cfg_wr_en) thresh_sq <= cfg_wr_data;
      if (in_tvalid && in_tready) norm_q.push_back(normalize(in_tuser[0], in_tdata, thresh_sq));
      if (out_tvalid && out_tready) begin
        got = {out_tuser[0], out_tdata[160:0]};
        if (norm_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %h", got);
        end else begin
          e = norm_q.pop_front();
          if (got !== e) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch x %h/%h y %h/%h z %h/%h w %h/%h len %h/%h dg %b/%b",
                       e.x, got.x, e.y, got.y, e.z, got.z, e.w, got.w,
                       e.len, got.len, e.degen, got.degen);
          end
        end
      end
    end
    pending <= norm_q.size();
  end

endmodule

`default_nettype wire

>>> dv/vector_normalizer_top_tb.sv
// testbench top for vector_normalizer_top: clock, reset, stimulus, verdict
// depends on vn_pkg, the rtl and vector_normalizer_checker
`default_nettype none

module vector_normalizer_top_tb;

  localparam int LATENCY = 60;       // 53-stage pipe plus margin
  localparam int IDLE_LIMIT = 5000;  // no-beat cycles before giving up

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // in_x, in_y, in_z, in_w
  logic [0:0]   in_tuser = '0;   // operation
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [167:0] out_tdata;       // out_x, out_y, out_z, out_w, orig_length, pad
  logic [0:0]   out_tuser;       // degenerate
  logic         cfg_wr_en = 0;
  logic [31:0]  cfg_wr_data = '0;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  bit           calm = 0;        // no idling in the final stretch
  bit           hold_sink = 0;   // long receiver hold-off

  always #1 clk = ~clk;

  vector_normalizer_top dut (.*);
  vector_normalizer_checker chk (.*);

  // watchdog: counts cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, plus a long hold-off when asked
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_sink) begin
        out_tready <= 0;
        repeat (200) @(posedge clk);
        hold_sink = 0;
      end else if (!calm && $urandom_range(3) == 0) begin
        n = $urandom_range(1, 6);
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1;
        @(posedge clk);
      end
    end
  end

  // random component: corners mixed with small, mid and full-range values
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  // one vector beat, with an optional random gap before it
  task automatic send_vec(logic op, logic [31:0] x, y, z, w);
    if (!calm && $urandom_range(4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {w, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // register writes only with the pipe drained
  task automatic write_thresh(logic [31:0] v);
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic random_vecs(int n);
    for (int i = 0; i < n; i++)
      send_vec(1'($urandom), rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: zero, tiny, threshold edges, largest sum, sign extremes
    send_vec(vn_pkg::OP_XYZ, 0, 0, 0, 32'h1234_5678);
    send_vec(vn_pkg::OP_XYZW, 0, 0, 0, 32'h1234_5678);
    send_vec(vn_pkg::OP_XYZ, 32'd65, 0, 0, 32'hffff_ffff);  // 4225, degenerate
    send_vec(vn_pkg::OP_XYZ, 32'd66, 0, 0, 0);              // 4356, just above
    send_vec(vn_pkg::OP_XYZW, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vec(vn_pkg::OP_XYZ, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vec(vn_pkg::OP_XYZW, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vec(vn_pkg::OP_XYZ, 32'h0001_0000, 32'hffff_0000, 0, 32'h8000_0000);
    send_vec(vn_pkg::OP_XYZW, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001);
    send_vec(vn_pkg::OP_XYZW, 0, 0, 0, 32'h0001_0000);
    send_vec(vn_pkg::OP_XYZ, 0, 0, 32'hfff0_0000, 32'h7fff_ffff);
    send_vec(vn_pkg::OP_XYZW, 32'h0003_0000, 32'h0004_0000, 0, 0);
    // threshold zero: any nonzero vector normalizes
    write_thresh(32'd0);
    send_vec(vn_pkg::OP_XYZ, 32'd1, 0, 0, 0);
    send_vec(vn_pkg::OP_XYZW, 0, 0, 0, 32'hffff_ffff);
    send_vec(vn_pkg::OP_XYZ, 0, 0, 0, 0);
    random_vecs(80);
    // largest threshold
    write_thresh(32'hffff_ffff);
    send_vec(vn_pkg::OP_XYZ, 32'h0001_0000, 0, 0, 0);  // exactly 2^32, above
    send_vec(vn_pkg::OP_XYZ, 32'h0000_ffff, 0, 0, 0);
    random_vecs(80);
    // random value, then back to reset value; the sink holds off for a while
    write_thresh($urandom);
    hold_sink = 1;
    random_vecs(100);
    write_thresh(vn_pkg::MIN_LEN_SQ_RST);
    random_vecs(80);
    calm = 1;
    random_vecs(60);
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

`default_nettype wire
